>>> src/page_frame_allocator_top_defines.svh
// Assertion macros for the page frame allocator.
// Each macro samples on the rising clock edge and is disabled during reset.
`ifndef PAGE_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// Check that a condition holds at every edge.
`define PFA_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define PFA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

   localparam int FRAME_COUNT_DEFAULT = 64;

   // used marks are kept as words of this many frames
   localparam int WORD_BITS = 8;
   localparam int BIT_W     = 3;

   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 6;
   localparam int OWNER_W  = 16;
   localparam int PAGE_W   = 20;
   localparam int COUNT_W  = 7;
   localparam int COUNT_MAX = 127;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_FREE   = 2'd1,
      MODE_ASSIGN = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_READ,
      ST_SCAN_CHECK,
      ST_LOOKUP,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

endpackage

`default_nettype wire

>>> src/page_frame_allocator_top.sv
// First-fit page frame allocator.
// Requests arrive on the req_ channel (valid/ready) as a mode, a frame index,
// an owner id and a virtual page; each one produces exactly one transfer on
// the rsp_ channel carrying the frame's contents after the operation and the
// count of free frames.
// The block works on one request at a time; req_ready is high only while it
// is idle and out of reset. Free, assign and query pass through the lookup
// (memory read), update and respond states before rsp_valid; an index beyond
// the table goes straight from idle to respond. Allocate scans the used-mark
// words, WORD_BITS frames per word, through one shared priority encoder, with
// a read and a check state per word; a grant, or a failure at the last word,
// goes to the respond state. The next request is taken in the cycle after the
// edge that loads the response register.
// Reset marks every frame free (per-word valid bits clear at once, no sweep)
// and sets the free count to FRAME_COUNT. While the receiver stalls, the
// response register holds; a finished result waits in the RESPOND state
// until the register frees up, and no new request is accepted meanwhile.
`default_nettype none
`include "page_frame_allocator_top_defines.svh"

module page_frame_allocator_top #(
   parameter int FRAME_COUNT = pfa_pkg::FRAME_COUNT_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [pfa_pkg::MODE_W-1:0]  req_mode,
   input  wire logic [pfa_pkg::INDEX_W-1:0] req_frame_index,
   input  wire logic [pfa_pkg::OWNER_W-1:0] req_owner_id,
   input  wire logic [pfa_pkg::PAGE_W-1:0]  req_virtual_page,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_success,
   output logic [pfa_pkg::INDEX_W-1:0]      rsp_result_frame,
   output logic                             rsp_entry_used,
   output logic [pfa_pkg::OWNER_W-1:0]      rsp_entry_owner,
   output logic [pfa_pkg::PAGE_W-1:0]       rsp_entry_page,
   output logic [pfa_pkg::COUNT_W-1:0]      rsp_free_count
);
   import pfa_pkg::*;

   localparam int NWORDS  = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int FIDX_W  = $clog2(FRAME_COUNT);
   localparam int CNT_W   = $clog2(FRAME_COUNT + 1);
   localparam int DATA_W  = OWNER_W + PAGE_W;

   // storage
   logic [WORD_BITS-1:0] used_mem [NWORDS];
   logic [DATA_W-1:0]    data_mem [FRAME_COUNT];
   logic [NWORDS-1:0]    word_valid_ff;

   state_type            state_ff, state_in;
   mode_type             mode_ff;
   logic [FIDX_W-1:0]    fidx_ff;
   logic [OWNER_W-1:0]   owner_ff;
   logic [PAGE_W-1:0]    page_ff;
   logic [WADDR_W-1:0]   scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]     free_total_ff, free_total_in;

   logic [WORD_BITS-1:0] rd_word_ff;
   logic                 rd_valid_ff;
   logic [DATA_W-1:0]    data_rd_ff;

   logic                 res_success_ff, res_success_in;
   logic [INDEX_W-1:0]   res_frame_ff, res_frame_in;
   logic                 res_used_ff, res_used_in;
   logic [OWNER_W-1:0]   res_owner_ff, res_owner_in;
   logic [PAGE_W-1:0]    res_page_ff, res_page_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_success_ff;
   logic [INDEX_W-1:0]   rsp_frame_ff;
   logic                 rsp_used_ff;
   logic [OWNER_W-1:0]   rsp_owner_ff;
   logic [PAGE_W-1:0]    rsp_page_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 req_accept;
   logic                 req_in_range;
   logic                 rsp_slot_free;
   logic [WADDR_W-1:0]   rd_addr;
   logic [WORD_BITS-1:0] word_base;
   logic [WORD_BITS-1:0] tail_mask;
   logic [WORD_BITS-1:0] free_vec;
   logic                 scan_hit;
   logic                 scan_last;
   logic [BIT_W-1:0]     hit_bit;
   logic [BIT_W-1:0]     cur_bit;
   logic                 cur_used;
   logic                 word_we;
   logic [WADDR_W-1:0]   word_wr_addr;
   logic [WORD_BITS-1:0] word_wr_data;
   logic                 data_we;
   logic [FIDX_W-1:0]    data_wr_addr;
   logic                 rsp_load;

   assign req_ready     = (state_ff == ST_IDLE) && !reset;
   assign req_accept    = req_valid && req_ready;
   assign req_in_range  = (32'(req_frame_index) < FRAME_COUNT);
   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;

   assign word_base = rd_valid_ff ? rd_word_ff : '0;
   assign cur_bit   = BIT_W'(fidx_ff);
   assign cur_used  = word_base[cur_bit];
   assign free_vec  = ~word_base & tail_mask;
   assign scan_hit  = |free_vec;
   assign scan_last = (scan_ptr_ff == WADDR_W'(NWORDS - 1));
   assign rd_addr   = (state_ff == ST_LOOKUP) ? WADDR_W'(fidx_ff >> BIT_W) : scan_ptr_ff;

   // frames past the end of the table count as used
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         tail_mask[b] = ((int'(scan_ptr_ff) * WORD_BITS + b) < FRAME_COUNT);
      end
   end

   always_comb begin
      hit_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_vec[b]) begin
            hit_bit = BIT_W'(b);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (mode_type'(req_mode) == MODE_ALLOC) begin
                  state_in = ST_SCAN_READ;
               end else if (req_in_range) begin
                  state_in = ST_LOOKUP;
               end else begin
                  state_in = ST_RESPOND;
               end
            end
         end
         ST_SCAN_READ:  state_in = ST_SCAN_CHECK;
         ST_SCAN_CHECK: begin
            if (scan_hit || scan_last) begin
               state_in = ST_RESPOND;
            end else begin
               state_in = ST_SCAN_READ;
            end
         end
         ST_LOOKUP:     state_in = ST_UPDATE;
         ST_UPDATE:     state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (rsp_slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      scan_ptr_in    = scan_ptr_ff;
      free_total_in  = free_total_ff;
      res_success_in = res_success_ff;
      res_frame_in   = res_frame_ff;
      res_used_in    = res_used_ff;
      res_owner_in   = res_owner_ff;
      res_page_in    = res_page_ff;
      word_we        = 1'b0;
      word_wr_addr   = WADDR_W'(fidx_ff >> BIT_W);
      word_wr_data   = word_base;
      data_we        = 1'b0;
      data_wr_addr   = fidx_ff;
      rsp_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // preset the answer for an index beyond the table
               scan_ptr_in    = '0;
               res_success_in = 1'b1;
               res_frame_in   = req_frame_index;
               res_used_in    = 1'b0;
               res_owner_in   = '0;
               res_page_in    = '0;
            end
         end
         ST_SCAN_CHECK: begin
            if (scan_hit) begin
               word_we        = 1'b1;
               word_wr_addr   = scan_ptr_ff;
               word_wr_data   = word_base | (WORD_BITS'(1) << hit_bit);
               data_we        = 1'b1;
               data_wr_addr   = FIDX_W'({scan_ptr_ff, hit_bit});
               if (free_total_ff != '0) begin
                  free_total_in = free_total_ff - CNT_W'(1);
               end
               res_success_in = 1'b1;
               res_frame_in   = INDEX_W'({scan_ptr_ff, hit_bit});
               res_used_in    = 1'b1;
               res_owner_in   = owner_ff;
               res_page_in    = page_ff;
            end else if (scan_last) begin
               res_success_in = 1'b0;
               res_frame_in   = '0;
               res_used_in    = 1'b0;
               res_owner_in   = '0;
               res_page_in    = '0;
            end else begin
               scan_ptr_in = scan_ptr_ff + WADDR_W'(1);
            end
         end
         ST_UPDATE: begin
            case (mode_ff)
               MODE_FREE: begin
                  word_we      = 1'b1;
                  word_wr_data = word_base & ~(WORD_BITS'(1) << cur_bit);
                  if (cur_used) begin
                     free_total_in = free_total_ff + CNT_W'(1);
                  end
                  res_used_in  = 1'b0;
                  res_owner_in = '0;
                  res_page_in  = '0;
               end
               MODE_ASSIGN: begin
                  word_we      = 1'b1;
                  word_wr_data = word_base | (WORD_BITS'(1) << cur_bit);
                  data_we      = 1'b1;
                  if (!cur_used && free_total_ff != '0) begin
                     free_total_in = free_total_ff - CNT_W'(1);
                  end
                  res_used_in  = 1'b1;
                  res_owner_in = owner_ff;
                  res_page_in  = page_ff;
               end
               default: begin
                  // query: owner and page of a free frame read as zero
                  res_used_in  = cur_used;
                  res_owner_in = cur_used ? data_rd_ff[DATA_W-1:PAGE_W] : '0;
                  res_page_in  = cur_used ? data_rd_ff[PAGE_W-1:0] : '0;
               end
            endcase
         end
         ST_RESPOND: begin
            rsp_load = rsp_slot_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_ptr_ff   <= '0;
         free_total_ff <= CNT_W'(FRAME_COUNT);
         word_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ptr_ff   <= scan_ptr_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (word_we) begin
            word_valid_ff[word_wr_addr] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= mode_type'(req_mode);
         fidx_ff  <= FIDX_W'(req_frame_index);
         owner_ff <= req_owner_id;
         page_ff  <= req_virtual_page;
      end
      res_success_ff <= res_success_in;
      res_frame_ff   <= res_frame_in;
      res_used_ff    <= res_used_in;
      res_owner_ff   <= res_owner_in;
      res_page_ff    <= res_page_in;
      if (rsp_load) begin
         rsp_success_ff <= res_success_ff;
         rsp_frame_ff   <= res_frame_ff;
         rsp_used_ff    <= res_used_ff;
         rsp_owner_ff   <= res_owner_ff;
         rsp_page_ff    <= res_page_ff;
         rsp_count_ff   <= (free_total_ff > CNT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                               : COUNT_W'(free_total_ff);
      end
   end

   // used-mark words
   always_ff @(posedge clock) begin
      if (word_we) begin
         used_mem[word_wr_addr] <= word_wr_data;
      end
      rd_word_ff  <= used_mem[rd_addr];
      rd_valid_ff <= word_valid_ff[rd_addr];
   end

   // owner and page entries
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_wr_addr] <= {owner_ff, page_ff};
      end
      data_rd_ff <= data_mem[fidx_ff];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_result_frame = rsp_frame_ff;
   assign rsp_entry_used   = rsp_used_ff;
   assign rsp_entry_owner  = rsp_owner_ff;
   assign rsp_entry_page   = rsp_page_ff;
   assign rsp_free_count   = rsp_count_ff;

   `PFA_ASSERT_ALWAYS(a_free_bound, 32'(free_total_ff) <= FRAME_COUNT,
      "free count above table size")
   `PFA_ASSERT_ALWAYS(a_scan_bound, 32'(scan_ptr_ff) < NWORDS, "scan pointer past last word")
   `PFA_ASSERT_NEXT(a_grant_count,
      state_ff == ST_SCAN_CHECK && scan_hit && free_total_ff != '0,
      free_total_ff == $past(free_total_ff) - CNT_W'(1), "grant did not take a free frame")
   `PFA_ASSERT_NEXT(a_respond, state_ff == ST_RESPOND && rsp_slot_free,
      rsp_valid_ff && state_ff == ST_IDLE, "finished result not presented")

endmodule

`default_nettype wire

>>> tb/tb_page_frame_allocator_top.sv
`default_nettype none

module tb_page_frame_allocator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pfa_pkg::*;

   localparam int FRAMES = 64;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic               success;
      logic [INDEX_W-1:0] frame;
      logic               used;
      logic [OWNER_W-1:0] owner;
      logic [PAGE_W-1:0]  page;
      logic [COUNT_W-1:0] count;
   } frame_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [MODE_W-1:0]  req_mode = MODE_QUERY;
   logic [INDEX_W-1:0] req_frame_index = '0;
   logic [OWNER_W-1:0] req_owner_id = '0;
   logic [PAGE_W-1:0]  req_virtual_page = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_success;
   logic [INDEX_W-1:0] rsp_result_frame;
   logic               rsp_entry_used;
   logic [OWNER_W-1:0] rsp_entry_owner;
   logic [PAGE_W-1:0]  rsp_entry_page;
   logic [COUNT_W-1:0] rsp_free_count;

   // frame table as the block should hold it
   logic               used_mark [FRAMES];
   logic [OWNER_W-1:0] owner_tab [FRAMES];
   logic [PAGE_W-1:0]  page_tab [FRAMES];
   int                 free_frames;

   frame_report_type frame_reports[$];
   int               mismatches = 0;
   int               req_burst_left = 0;
   int               rsp_burst_left = 0;

   page_frame_allocator_top #(
      .FRAME_COUNT(FRAMES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_frame_index (req_frame_index),
      .req_owner_id    (req_owner_id),
      .req_virtual_page(req_virtual_page),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_success     (rsp_success),
      .rsp_result_frame(rsp_result_frame),
      .rsp_entry_used  (rsp_entry_used),
      .rsp_entry_owner (rsp_entry_owner),
      .rsp_entry_page  (rsp_entry_page),
      .rsp_free_count  (rsp_free_count)
   );

   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

   // Mostly a random idle gap, which may be none, with occasional stretches of back-to-back transfers.
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic void clear_table();
      int i;
      for (i = 0; i < FRAMES; i++) begin
         used_mark[i] = 1'b0;
         owner_tab[i] = '0;
         page_tab[i]  = '0;
      end
      free_frames = FRAMES;
   endfunction

   // Apply one request to the table and return the report it should produce.
   function automatic frame_report_type run_table_op(mode_type op, logic [INDEX_W-1:0] idx,
                                                     logic [OWNER_W-1:0] owner,
                                                     logic [PAGE_W-1:0] page);
      frame_report_type r;
      int slot;
      int i;
      r = '0;
      r.success = 1'b1;
      slot = -1;
      if (op == MODE_ALLOC) begin
         for (i = FRAMES - 1; i >= 0; i--)
            if (!used_mark[i]) slot = i;
         if (slot < 0) begin
            r.success = 1'b0;
         end else begin
            used_mark[slot] = 1'b1;
            owner_tab[slot] = owner;
            page_tab[slot]  = page;
            if (free_frames > 0) free_frames--;
            r.frame = INDEX_W'(slot);
         end
      end else begin
         r.frame = idx;
         if (int'(idx) < FRAMES) begin
            slot = int'(idx);
            case (op)
               MODE_FREE: begin
                  if (used_mark[slot]) free_frames++;
                  used_mark[slot] = 1'b0;
                  owner_tab[slot] = '0;
                  page_tab[slot]  = '0;
               end
               MODE_ASSIGN: begin
                  if (!used_mark[slot] && free_frames > 0) free_frames--;
                  used_mark[slot] = 1'b1;
                  owner_tab[slot] = owner;
                  page_tab[slot]  = page;
               end
               default: ;
            endcase
         end
      end
      if (slot >= 0) begin
         r.used  = used_mark[slot];
         r.owner = owner_tab[slot];
         r.page  = page_tab[slot];
      end
      r.count = (free_frames > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(free_frames);
      return r;
   endfunction

   function automatic logic [INDEX_W-1:0] pick_used_frame();
      int start;
      int k;
      start = $urandom_range(0, FRAMES - 1);
      for (k = 0; k < FRAMES; k++)
         if (used_mark[(start + k) % FRAMES]) return INDEX_W'((start + k) % FRAMES);
      return INDEX_W'(start);
   endfunction

   // Keep valid high across back-to-back requests; drop it only for a gap.
   task automatic send_request(mode_type op, logic [INDEX_W-1:0] idx,
                               logic [OWNER_W-1:0] owner, logic [PAGE_W-1:0] page);
      int gap;
      gap = draw_wait(req_burst_left);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= op;
      req_frame_index  <= idx;
      req_owner_id     <= owner;
      req_virtual_page <= page;
      do @(posedge clock); while (!req_ready);
      frame_reports.push_back(run_table_op(op, idx, owner, page));
   endtask

   initial begin : result_monitor
      int stall;
      frame_report_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_burst_left);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (frame_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: result transfer with nothing outstanding, frame %0d",
                        rsp_result_frame);
         end else begin
            want = frame_reports.pop_front();
            if (rsp_success !== want.success || rsp_result_frame !== want.frame ||
                rsp_entry_used !== want.used || rsp_entry_owner !== want.owner ||
                rsp_entry_page !== want.page || rsp_free_count !== want.count) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("tb: mismatch exp ok=%0b frame=%0d used=%0b owner=%h page=%h free=%0d",
                           want.success, want.frame, want.used, want.owner, want.page,
                           want.count);
                  $display("tb:          got ok=%0b frame=%0d used=%0b owner=%h page=%h free=%0d",
                           rsp_success, rsp_result_frame, rsp_entry_used,
                           rsp_entry_owner, rsp_entry_page, rsp_free_count);
               end
            end
         end
      end
   end

   task automatic test_reset_contents();
      send_request(MODE_QUERY, 6'd0, '0, '0);
      send_request(MODE_QUERY, 6'd63, '1, '1);
      send_request(MODE_QUERY, 6'd31, 16'h5a5a, 20'ha5a5a);
   endtask

   task automatic test_allocate();
      send_request(MODE_ALLOC, 6'd63, 16'hffff, 20'hfffff);
      send_request(MODE_ALLOC, 6'd0, 16'h0000, 20'h00000);
      send_request(MODE_ALLOC, 6'd17, 16'h1234, 20'h56789);
      send_request(MODE_QUERY, 6'd0, '0, '0);
   endtask

   task automatic test_free();
      send_request(MODE_FREE, 6'd1, '1, '1);
      send_request(MODE_FREE, 6'd1, '0, '0);
      send_request(MODE_FREE, 6'd40, '0, '0);
      // lowest free frame is 1 again
      send_request(MODE_ALLOC, 6'd5, 16'h8001, 20'h80001);
   endtask

   task automatic test_assign();
      send_request(MODE_ASSIGN, 6'd63, 16'hffff, 20'hfffff);
      send_request(MODE_ASSIGN, 6'd63, 16'h0001, 20'h00001);
      send_request(MODE_ASSIGN, 6'd0, 16'hbeef, 20'h12345);
      send_request(MODE_QUERY, 6'd63, '0, '0);
      send_request(MODE_FREE, 6'd63, '0, '0);
      send_request(MODE_QUERY, 6'd63, '1, '1);
   endtask

   task automatic test_full_table();
      while (free_frames > 0)
         send_request(MODE_ALLOC, INDEX_W'($urandom()), OWNER_W'($urandom()),
                      PAGE_W'($urandom()));
      send_request(MODE_ALLOC, 6'd0, 16'hffff, 20'hfffff);
      send_request(MODE_ASSIGN, 6'd40, 16'h4040, 20'h40404);
      send_request(MODE_FREE, 6'd40, '0, '0);
      send_request(MODE_ALLOC, 6'd0, 16'h7777, 20'h77777);
      send_request(MODE_ALLOC, 6'd0, 16'h0000, 20'h00000);
   endtask

   // Each block of 40 requests is filling, draining or mixed traffic, picked at random.
   task automatic test_random_traffic(int count);
      int n;
      int wa, wf, ws, wq, pick;
      mode_type op;
      logic [INDEX_W-1:0] idx;
      wa = 1; wf = 1; ws = 1; wq = 1;
      for (n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  wa = 8;
                  wf = 1;
               end
               1: begin
                  wa = 1;
                  wf = 8;
               end
               default: begin
                  wa = $urandom_range(1, 6);
                  wf = $urandom_range(1, 6);
               end
            endcase
            ws = $urandom_range(1, 4);
            wq = $urandom_range(1, 4);
         end
         pick = $urandom_range(0, wa + wf + ws + wq - 1);
         if (pick < wa) op = MODE_ALLOC;
         else if (pick < wa + wf) op = MODE_FREE;
         else if (pick < wa + wf + ws) op = MODE_ASSIGN;
         else op = MODE_QUERY;
         if (op != MODE_ASSIGN && $urandom_range(0, 3) != 0) idx = pick_used_frame();
         else idx = INDEX_W'($urandom_range(0, FRAMES - 1));
         send_request(op, idx, OWNER_W'($urandom()), PAGE_W'($urandom()));
      end
   endtask

   initial begin
      clear_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_contents();
      test_allocate();
      test_free();
      test_assign();
      test_full_table();
      test_random_traffic(800);
      req_valid <= 1'b0;
      while (frame_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && frame_reports.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
